// File: rtl/tzr_pkg.sv
// Shared types and constants of the triangle rasterizer with depth store.
package tzr_pkg;

  localparam logic [1:0] CMD_DRAW = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;

  localparam logic [1:0] ST_DRAWN   = 2'd0;
  localparam logic [1:0] ST_CULLED  = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int DIV_W = 50;
  localparam int QUO_W = 49;

  localparam logic [5:0] INV_STEPS  = 6'd33;
  localparam logic [5:0] FRAC_STEPS = 6'd16;
  localparam logic [5:0] DEP_STEPS  = 6'd49;

  localparam logic [16:0] UV_ONE = 17'h10000;
  localparam logic [23:0] Z_MAX  = 24'hFFFFFF;

  typedef struct packed {
    logic       start;
    logic       lead;
    logic [5:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic [23:0] depth;
    logic [16:0] u;
    logic [16:0] v;
  } entry_t;

endpackage

// File: rtl/tzr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tzr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tzr_div.sv
// Shared restoring divider, one quotient bit per cycle.
module tzr_div
  import tzr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;
  logic [QUO_W-1:0] dvd_r;
  logic [QUO_W-1:0] quo_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, dvd_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        rem_r  <= num;
        den_r  <= den;
        dvd_r  <= {ctl.lead, {(QUO_W-1){1'b0}}};
        quo_r  <= '0;
        cnt_r  <= ctl.steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], ge};
        dvd_r <= {dvd_r[QUO_W-2:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: rtl/triangle_rasterizer_zbuffer.sv
// Top level: command sequencer, edge walk and depth-tested pixel store.
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  draw, read or clear command
//   out_     output     out_valid/out_stall one status word per command
//   cfg_     input      cfg_we             width/height register write
//
// Clear writes one store entry per cycle. A draw runs setup and one reciprocal
// per vertex, then tests each box pixel; each covered pixel takes up to three
// weight, one depth and two u/v divisions (shared bit-serial divider).
// Reset starts a clearing pass over all BUFFER_WORDS entries; no command is taken
// until it ends. in_stall is high while a command is in work; a result waits
// in the output register while out_stall is high.
module triangle_rasterizer_zbuffer
  import tzr_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int BUFFER_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_vert0_x,
  input  logic signed [15:0] in_vert0_y,
  input  logic [23:0]        in_vert0_z,
  input  logic signed [15:0] in_vert1_x,
  input  logic signed [15:0] in_vert1_y,
  input  logic [23:0]        in_vert1_z,
  input  logic signed [15:0] in_vert2_x,
  input  logic signed [15:0] in_vert2_y,
  input  logic [23:0]        in_vert2_z,
  input  logic [15:0]        in_read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [16:0]        out_pixels_written,
  output logic [23:0]        out_pixel_depth,
  output logic [16:0]        out_pixel_u,
  output logic [16:0]        out_pixel_v,
  output logic               out_pixel_valid,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int AW = $clog2(BUFFER_WORDS);

  typedef enum logic [22:0] {
    S_CLR     = 23'h000001,
    S_IDLE    = 23'h000002,
    S_RD      = 23'h000004,
    S_RDW     = 23'h000008,
    S_AREA0   = 23'h000010,
    S_AREA1   = 23'h000020,
    S_AREA2   = 23'h000040,
    S_CULL    = 23'h000080,
    S_EDGE0   = 23'h000100,
    S_EDGE1   = 23'h000200,
    S_EDGE2   = 23'h000400,
    S_INV     = 23'h000800,
    S_ROWINIT = 23'h001000,
    S_PIX     = 23'h002000,
    S_TEST    = 23'h004000,
    S_WGT     = 23'h008000,
    S_MUL     = 23'h010000,
    S_ACC     = 23'h020000,
    S_DEP     = 23'h040000,
    S_UVQ     = 23'h080000,
    S_WR      = 23'h100000,
    S_NEXT    = 23'h200000,
    S_DONE    = 23'h400000
  } state_t;

  state_t state_r;
  logic [1:0] k_r;
  logic       wait_r;
  logic       clr_cmd_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] addr_r;

  logic [8:0] width_r;
  logic [8:0] height_r;

  logic signed [15:0] px_r [3];
  logic signed [15:0] py_r [3];
  logic [23:0]        vz_r [3];
  logic [15:0]        rindex_r;

  logic [10:0]        minx_r, miny_r;
  logic signed [13:0] maxx_r, maxy_r;
  logic signed [35:0] prod_a_r, area_r;
  logic signed [51:0] mul_r;
  logic signed [39:0] row_acc_r [3];
  logic signed [39:0] cur_r [3];
  logic [32:0]        inv_r [3];
  logic [16:0]        c_r [3];
  logic [49:0]        s_r, s1_r, s2_r;
  logic [23:0]        z_r;
  logic [16:0]        u_r, v_r;
  logic [8:0]         x_r, y_r;
  logic [17:0]        idx_r;
  logic [16:0]        cnt_r;

  logic [1:0]  res_status_r;
  logic [23:0] res_depth_r;
  logic [16:0] res_u_r, res_v_r;
  logic        res_pv_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [16:0] out_cnt_r, out_u_r, out_v_r;
  logic [23:0] out_depth_r;
  logic        out_pv_r;
  logic        out_load;

  logic [8:0] wdt, hgt;
  logic signed [15:0] mnx, mxx, mny, mxy;
  logic [10:0]        minx_c, miny_c;
  logic signed [13:0] maxx_c, maxy_c;

  logic signed [15:0] ax, ay, bx, by;
  logic signed [16:0] d_px20, d_py10, d_py20, d_px10;
  logic signed [17:0] mul_x;
  logic signed [33:0] mul_y;
  logic signed [39:0] dx [3];
  logic signed [39:0] dy [3];

  logic signed [39:0] cur_sel;
  logic [39:0]        neg_cur;
  logic [49:0]        wnum, darea, uvnum;
  logic               wsat, uvsat, covered, idx_ok, rd_ok, pass;
  logic               x_end, y_end;

  div_ctl_t           div_ctl;
  logic [DIV_W-1:0]   div_num, div_den;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata, mem_rdata;

  function automatic logic [8:0] clamp_dim(input logic [8:0] v, input int maxv);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (int'(v) > maxv) begin
      r = 9'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c);
    logic signed [15:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c);
    logic signed [15:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  function automatic logic [10:0] lo_bound(input logic signed [15:0] v);
    return v[15] ? 11'd0 : v[14:4];
  endfunction

  function automatic logic signed [13:0] hi_bound(input logic signed [15:0] v,
      input logic [8:0] lim);
    logic [16:0]        mag;
    logic signed [13:0] t;
    mag = 17'(-{v[15], v});
    if (v[15]) begin
      t = 14'sd0 - $signed({1'b0, mag[16:4]});
    end else begin
      t = $signed({3'b0, v[14:4]});
    end
    t = t + 14'sd1;
    if (t > $signed({5'b0, lim})) begin
      t = $signed({5'b0, lim});
    end
    return t;
  endfunction

  function automatic logic nonpos(input logic signed [39:0] v);
    return v[39] | (v == 40'sd0);
  endfunction

  assign wdt = clamp_dim(width_r, MAX_WIDTH);
  assign hgt = clamp_dim(height_r, MAX_HEIGHT);

  assign mnx = min3(px_r[0], px_r[1], px_r[2]);
  assign mxx = max3(px_r[0], px_r[1], px_r[2]);
  assign mny = min3(py_r[0], py_r[1], py_r[2]);
  assign mxy = max3(py_r[0], py_r[1], py_r[2]);
  assign minx_c = lo_bound(mnx);
  assign miny_c = lo_bound(mny);
  assign maxx_c = hi_bound(mxx, wdt);
  assign maxy_c = hi_bound(mxy, hgt);

  assign d_px20 = px_r[2] - px_r[0];
  assign d_py10 = py_r[1] - py_r[0];
  assign d_py20 = py_r[2] - py_r[0];
  assign d_px10 = px_r[1] - px_r[0];

  always_comb begin
    case (k_r)
      2'd0: begin
        ax = px_r[1]; ay = py_r[1]; bx = px_r[2]; by = py_r[2];
      end
      2'd1: begin
        ax = px_r[2]; ay = py_r[2]; bx = px_r[0]; by = py_r[0];
      end
      default: begin
        ax = px_r[0]; ay = py_r[0]; bx = px_r[1]; by = py_r[1];
      end
    endcase
  end

  assign dx[0] = 40'(17'(py_r[2] - py_r[1])) <<< 4;
  assign dy[0] = 40'(17'(px_r[1] - px_r[2])) <<< 4;
  assign dx[1] = 40'(17'(py_r[0] - py_r[2])) <<< 4;
  assign dy[1] = 40'(17'(px_r[2] - px_r[0])) <<< 4;
  assign dx[2] = 40'(17'(py_r[1] - py_r[0])) <<< 4;
  assign dy[2] = 40'(17'(px_r[0] - px_r[1])) <<< 4;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      S_AREA0: begin
        mul_x = 18'(d_px20);
        mul_y = 34'(d_py10);
      end
      S_AREA1: begin
        mul_x = 18'(d_py20);
        mul_y = 34'(d_px10);
      end
      S_EDGE0: begin
        mul_x = $signed({3'b0, minx_r, 4'b0}) - 18'(ax);
        mul_y = 34'(17'(by - ay));
      end
      S_EDGE1: begin
        mul_x = $signed({3'b0, miny_r, 4'b0}) - 18'(ay);
        mul_y = 34'(17'(bx - ax));
      end
      S_MUL: begin
        mul_x = $signed({1'b0, c_r[k_r]});
        mul_y = $signed({1'b0, inv_r[k_r]});
      end
      default: begin
        mul_x = '0;
      end
    endcase
  end

  assign cur_sel = cur_r[k_r];
  assign neg_cur = 40'(-cur_sel);
  assign wnum    = {10'b0, neg_cur};
  assign darea   = {14'b0, 36'(-area_r)};
  assign wsat    = wnum >= darea;
  assign uvnum   = k_r[0] ? s2_r : s1_r;
  assign uvsat   = (s_r == 50'd0) || (uvnum >= s_r);
  assign covered = nonpos(cur_r[0]) && nonpos(cur_r[1]) && nonpos(cur_r[2]);
  assign idx_ok  = int'(idx_r) < BUFFER_WORDS;
  assign rd_ok   = int'(rindex_r) < BUFFER_WORDS;
  assign pass    = (mem_rdata.depth == 24'd0) || (mem_rdata.depth > z_r);
  assign x_end   = ({1'b0, x_r} + 10'd1) == maxx_r[9:0];
  assign y_end   = ({1'b0, y_r} + 10'd1) == maxy_r[9:0];

  always_comb begin
    div_ctl = '0;
    div_num = '0;
    div_den = '0;
    case (state_r)
      S_INV: begin
        div_den       = {26'b0, vz_r[k_r]};
        div_ctl.lead  = 1'b1;
        div_ctl.steps = INV_STEPS;
        div_ctl.start = !wait_r;
      end
      S_WGT: begin
        div_num       = wnum;
        div_den       = darea;
        div_ctl.steps = FRAC_STEPS;
        div_ctl.start = !wait_r && !wsat;
      end
      S_DEP: begin
        div_den       = s_r;
        div_ctl.lead  = 1'b1;
        div_ctl.steps = DEP_STEPS;
        div_ctl.start = !wait_r && (s_r != 50'd0);
      end
      S_UVQ: begin
        div_num       = uvnum;
        div_den       = s_r;
        div_ctl.steps = FRAC_STEPS;
        div_ctl.start = !wait_r && !uvsat;
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  tzr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign mem_we    = (state_r == S_CLR) || ((state_r == S_WR) && pass);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : addr_r;
  assign mem_wdata = (state_r == S_CLR) ? entry_t'('0) : entry_t'({z_r, u_r, v_r});

  tzr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(BUFFER_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(addr_r),
    .rdata(mem_rdata)
  );

  assign in_stall = state_r != S_IDLE;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      k_r       <= 2'd0;
      wait_r    <= 1'b0;
      clr_cmd_r <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(BUFFER_WORDS - 1)) begin
            res_status_r <= ST_CLEARED;
            state_r      <= clr_cmd_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            px_r[0]  <= in_vert0_x;
            py_r[0]  <= in_vert0_y;
            vz_r[0]  <= (in_vert0_z == 24'd0) ? 24'd1 : in_vert0_z;
            px_r[1]  <= in_vert1_x;
            py_r[1]  <= in_vert1_y;
            vz_r[1]  <= (in_vert1_z == 24'd0) ? 24'd1 : in_vert1_z;
            px_r[2]  <= in_vert2_x;
            py_r[2]  <= in_vert2_y;
            vz_r[2]  <= (in_vert2_z == 24'd0) ? 24'd1 : in_vert2_z;
            rindex_r <= in_read_index;
            addr_r   <= AW'(in_read_index);
            cnt_r        <= '0;
            res_status_r <= ST_DRAWN;
            res_depth_r  <= '0;
            res_u_r      <= '0;
            res_v_r      <= '0;
            res_pv_r     <= 1'b0;
            k_r          <= 2'd0;
            wait_r       <= 1'b0;
            case (in_command)
              CMD_DRAW: state_r <= S_AREA0;
              CMD_READ: state_r <= S_RD;
              default: begin
                clr_cnt_r <= '0;
                clr_cmd_r <= 1'b1;
                state_r   <= S_CLR;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          res_status_r <= ST_READ;
          if (rd_ok) begin
            res_depth_r <= mem_rdata.depth;
            res_u_r     <= mem_rdata.u;
            res_v_r     <= mem_rdata.v;
            res_pv_r    <= mem_rdata.depth != 24'd0;
          end
          state_r <= S_DONE;
        end
        S_AREA0: begin
          minx_r  <= minx_c;
          miny_r  <= miny_c;
          maxx_r  <= maxx_c;
          maxy_r  <= maxy_c;
          state_r <= S_AREA1;
        end
        S_AREA1: begin
          prod_a_r <= mul_r[35:0];
          state_r  <= S_AREA2;
        end
        S_AREA2: begin
          area_r  <= prod_a_r - $signed(mul_r[35:0]);
          state_r <= S_CULL;
        end
        S_CULL: begin
          if (!area_r[35]) begin
            res_status_r <= ST_CULLED;
            state_r      <= S_DONE;
          end else if (($signed({3'b0, minx_r}) >= maxx_r) ||
                       ($signed({3'b0, miny_r}) >= maxy_r)) begin
            state_r <= S_DONE;
          end else begin
            k_r     <= 2'd0;
            state_r <= S_EDGE0;
          end
        end
        S_EDGE0: begin
          state_r <= S_EDGE1;
        end
        S_EDGE1: begin
          prod_a_r <= mul_r[35:0];
          state_r  <= S_EDGE2;
        end
        S_EDGE2: begin
          row_acc_r[k_r] <= 40'(prod_a_r) - 40'($signed(mul_r[35:0]));
          if (k_r == 2'd2) begin
            k_r     <= 2'd0;
            state_r <= S_INV;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_EDGE0;
          end
        end
        S_INV: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            inv_r[k_r] <= div_quo[32:0];
            wait_r     <= 1'b0;
            if (k_r == 2'd2) begin
              k_r     <= 2'd0;
              state_r <= S_ROWINIT;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_ROWINIT: begin
          x_r      <= minx_r[8:0];
          y_r      <= miny_r[8:0];
          cur_r[0] <= row_acc_r[0];
          cur_r[1] <= row_acc_r[1];
          cur_r[2] <= row_acc_r[2];
          state_r  <= S_PIX;
        end
        S_PIX: begin
          idx_r   <= 18'({9'b0, y_r} * {9'b0, wdt}) + {9'b0, x_r};
          state_r <= S_TEST;
        end
        S_TEST: begin
          addr_r <= AW'(idx_r);
          k_r    <= 2'd0;
          state_r <= (covered && idx_ok) ? S_WGT : S_NEXT;
        end
        S_WGT: begin
          if (!wait_r && wsat) begin
            c_r[k_r] <= UV_ONE;
            k_r      <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
            if (k_r == 2'd2) state_r <= S_MUL;
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            c_r[k_r] <= div_quo[16:0];
            wait_r   <= 1'b0;
            k_r      <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
            if (k_r == 2'd2) state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          s_r <= ((k_r == 2'd0) ? 50'd0 : s_r) + mul_r[49:0];
          if (k_r == 2'd1) s1_r <= mul_r[49:0];
          if (k_r == 2'd2) s2_r <= mul_r[49:0];
          if (k_r == 2'd2) begin
            k_r     <= 2'd0;
            state_r <= S_DEP;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_DEP: begin
          if (!wait_r && (s_r == 50'd0)) begin
            z_r     <= Z_MAX;
            state_r <= S_UVQ;
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            wait_r <= 1'b0;
            if (div_quo > QUO_W'(Z_MAX)) begin
              z_r <= Z_MAX;
            end else if (div_quo == '0) begin
              z_r <= 24'd1;
            end else begin
              z_r <= div_quo[23:0];
            end
            state_r <= S_UVQ;
          end
        end
        S_UVQ: begin
          if (!wait_r && uvsat) begin
            if (k_r[0]) v_r <= UV_ONE;
            else u_r <= UV_ONE;
            k_r <= k_r[0] ? 2'd0 : 2'd1;
            if (k_r[0]) state_r <= S_WR;
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            if (k_r[0]) v_r <= div_quo[16:0];
            else u_r <= div_quo[16:0];
            wait_r <= 1'b0;
            k_r    <= k_r[0] ? 2'd0 : 2'd1;
            if (k_r[0]) state_r <= S_WR;
          end
        end
        S_WR: begin
          if (pass) cnt_r <= cnt_r + 17'd1;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (x_end) begin
            if (y_end) begin
              state_r <= S_DONE;
            end else begin
              y_r <= y_r + 9'd1;
              x_r <= minx_r[8:0];
              row_acc_r[0] <= row_acc_r[0] + dy[0];
              row_acc_r[1] <= row_acc_r[1] + dy[1];
              row_acc_r[2] <= row_acc_r[2] + dy[2];
              cur_r[0]     <= row_acc_r[0] + dy[0];
              cur_r[1]     <= row_acc_r[1] + dy[1];
              cur_r[2]     <= row_acc_r[2] + dy[2];
              state_r <= S_PIX;
            end
          end else begin
            x_r      <= x_r + 9'd1;
            cur_r[0] <= cur_r[0] + dx[0];
            cur_r[1] <= cur_r[1] + dx[1];
            cur_r[2] <= cur_r[2] + dx[2];
            state_r  <= S_PIX;
          end
        end
        S_DONE: begin
          clr_cmd_r <= 1'b0;
          if (out_load) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res_status_r;
      out_cnt_r    <= (res_status_r == ST_DRAWN) ? cnt_r : 17'd0;
      out_depth_r  <= res_depth_r;
      out_u_r      <= res_u_r;
      out_v_r      <= res_v_r;
      out_pv_r     <= res_pv_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_pixels_written = out_cnt_r;
  assign out_pixel_depth    = out_depth_r;
  assign out_pixel_u        = out_u_r;
  assign out_pixel_v        = out_v_r;
  assign out_pixel_valid    = out_pv_r;

endmodule
